### design/assert_macros.svh
// Assertion macros for the XOR parity stripe generator.
// Takes no other file; the top level includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a clocked property, off during reset.
`define XPSG_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// Check that a condition never holds at a clock edge.
`define XPSG_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define XPSG_ASSERT(lbl, ck, rn, prop, msg)
`define XPSG_NEVER(lbl, ck, rn, cond, msg)
`endif

`endif

### design/xpsg_pkg.sv
// Shared types and constants of the XOR parity stripe generator.
// Depends on nothing; the controller, datapath and top level take names from it by scope.
`timescale 1ns / 1ps

package xpsg_pkg;

    localparam int MAX_BLOCK_DEF = 32;
    localparam int MAX_DISKS_DEF = 16;
    localparam int MIN_DISKS     = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [4:0] NUM_DISKS_RST  = 5'd3;
    localparam logic [5:0] BLOCK_SIZE_RST = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_DISKS  = 2'd0,
        REG_BLOCK_SIZE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_req;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]  disk_index;
        logic [15:0] stripe_index;
        logic [4:0]  byte_offset;
        logic [7:0]  out_byte;
        logic        is_parity;
        logic        last_of_run;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA,
        ST_PAR,
        ST_FL_RD,
        ST_FL_EM
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;      // latch input beat, read its parity entry
        logic rd_flush;    // read parity entry at flush index
        logic emit_data;   // load data beat, update parity entry
        logic emit_par;    // load finished parity beat
        logic emit_flush;  // load flushed parity beat
        logic finish;      // advance counters, or clear after a final beat
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;    // output register can take a beat this cycle
        logic fin;         // current item is the final one
        logic last_disk;   // current item is on the last data disk
        logic off_end;     // current offset is the last of the block
        logic flush_end;   // flush index is the last of the block
    } sts_t;

endpackage

### design/xpsg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module xpsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/xpsg_ctrl.sv
// Sequencer of the XOR parity stripe generator.
// Depends on xpsg_pkg for the state, command and status types.
`timescale 1ns / 1ps

module xpsg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  xpsg_pkg::sts_t sts,
    output xpsg_pkg::cmd_t cmd
);

    xpsg_pkg::state_t state_reg;
    xpsg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xpsg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        cfg_ready  = 1'b0;
        case (state_reg)
            xpsg_pkg::ST_IDLE:
            begin
                // Hold the input while a register write is offered.
                in_stall  = cfg_valid;
                cfg_ready = 1'b1;
                if (in_valid && !cfg_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = xpsg_pkg::ST_DATA;
                end
            end
            xpsg_pkg::ST_DATA:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    if (sts.last_disk)
                    begin
                        state_next = xpsg_pkg::ST_PAR;
                    end
                    else if (sts.fin)
                    begin
                        state_next = xpsg_pkg::ST_FL_RD;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = xpsg_pkg::ST_IDLE;
                    end
                end
            end
            xpsg_pkg::ST_PAR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_par = 1'b1;
                    if (sts.fin && !sts.off_end)
                    begin
                        state_next = xpsg_pkg::ST_FL_RD;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = xpsg_pkg::ST_IDLE;
                    end
                end
            end
            xpsg_pkg::ST_FL_RD:
            begin
                cmd.rd_flush = 1'b1;
                state_next   = xpsg_pkg::ST_FL_EM;
            end
            xpsg_pkg::ST_FL_EM:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    if (sts.flush_end)
                    begin
                        cmd.finish = 1'b1;
                        state_next = xpsg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = xpsg_pkg::ST_FL_RD;
                    end
                end
            end
            default:
            begin
                state_next = xpsg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/xpsg_datapath.sv
// Datapath of the XOR parity stripe generator: config registers, stream
// counters, parity RAM with valid bits, output register.
// Depends on xpsg_pkg and xpsg_ram.
`timescale 1ns / 1ps

module xpsg_datapath #(
    parameter int MAX_BLOCK = xpsg_pkg::MAX_BLOCK_DEF,
    parameter int MAX_DISKS = xpsg_pkg::MAX_DISKS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [xpsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [xpsg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  xpsg_pkg::in_beat_t                   in_data,
    input  xpsg_pkg::cmd_t                       cmd,
    output xpsg_pkg::sts_t                       sts,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output xpsg_pkg::out_beat_t                  out_data
);

    localparam int OW  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int BSW = ($clog2(MAX_BLOCK + 1) > 6) ? $clog2(MAX_BLOCK + 1) : 6;
    localparam int DKW = $clog2(MAX_DISKS);
    localparam int NDW = ($clog2(MAX_DISKS + 1) > 5) ? $clog2(MAX_DISKS + 1) : 5;

    logic [4:0]           num_disks_reg, num_disks_next;
    logic [5:0]           block_size_reg, block_size_next;
    logic [OW-1:0]        offset_cnt_reg, offset_cnt_next;
    logic [DKW-1:0]       disk_cnt_reg, disk_cnt_next;
    logic [15:0]          stripe_cnt_reg, stripe_cnt_next;
    logic [MAX_BLOCK-1:0] valid_reg, valid_next;
    logic [OW-1:0]        off_reg, off_next;
    logic [DKW-1:0]       disk_reg, disk_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 fin_reg, fin_next;
    logic [7:0]           par_reg, par_next;
    logic [OW-1:0]        flush_idx_reg, flush_idx_next;
    logic                 out_valid_reg, out_valid_next;
    xpsg_pkg::out_beat_t  out_reg, out_next;

    logic [NDW-1:0] nd_ext, nd_eff;
    logic [BSW-1:0] bs_ext, bs_eff, bs_last, off_inc;
    logic [DKW-1:0] last_data, par_disk, disk_norm;
    logic [OW-1:0]  off_norm, ram_rd_addr;
    logic [7:0]     ram_q, xor_val, flush_val;
    logic           is_last_disk, out_free, ram_rd_en, ram_wr_en;

    // Effective geometry, saturated to the legal ranges.
    always_comb
    begin
        nd_ext = NDW'(num_disks_reg);
        if (nd_ext < NDW'(xpsg_pkg::MIN_DISKS))
        begin
            nd_eff = NDW'(xpsg_pkg::MIN_DISKS);
        end
        else if (nd_ext > NDW'(MAX_DISKS))
        begin
            nd_eff = NDW'(MAX_DISKS);
        end
        else
        begin
            nd_eff = nd_ext;
        end
        bs_ext = BSW'(block_size_reg);
        if (bs_ext == '0)
        begin
            bs_eff = BSW'(1);
        end
        else if (bs_ext > BSW'(MAX_BLOCK))
        begin
            bs_eff = BSW'(MAX_BLOCK);
        end
        else
        begin
            bs_eff = bs_ext;
        end
    end

    assign last_data    = DKW'(nd_eff - NDW'(2));
    assign par_disk     = DKW'(nd_eff - NDW'(1));
    assign bs_last      = bs_eff - BSW'(1);
    assign off_inc      = BSW'(off_reg) + BSW'(1);
    assign off_norm     = (BSW'(offset_cnt_reg) >= bs_eff) ? '0 : offset_cnt_reg;
    assign disk_norm    = (disk_cnt_reg > last_data) ? '0 : disk_cnt_reg;
    assign is_last_disk = (disk_reg == last_data);
    assign out_free     = !out_valid_reg || !out_stall;

    // Entries never written since the last clear read as zero.
    assign xor_val   = (valid_reg[off_reg] ? ram_q : 8'd0) ^ byte_reg;
    assign flush_val = valid_reg[flush_idx_reg] ? ram_q : 8'd0;

    assign ram_rd_en   = cmd.accept || cmd.rd_flush;
    assign ram_rd_addr = cmd.accept ? off_norm : flush_idx_reg;
    assign ram_wr_en   = cmd.emit_data && !is_last_disk;

    xpsg_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BLOCK)
    ) u_par_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (off_reg),
        .wr_data (xor_val),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    always_comb
    begin
        num_disks_next  = num_disks_reg;
        block_size_next = block_size_reg;
        offset_cnt_next = offset_cnt_reg;
        disk_cnt_next   = disk_cnt_reg;
        stripe_cnt_next = stripe_cnt_reg;
        valid_next      = valid_reg;
        off_next        = off_reg;
        disk_next       = disk_reg;
        byte_next       = byte_reg;
        fin_next        = fin_reg;
        par_next        = par_reg;
        flush_idx_next  = flush_idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;

        if (cmd.accept)
        begin
            off_next  = off_norm;
            disk_next = disk_norm;
            byte_next = in_data.data_byte;
            fin_next  = in_data.final_req;
        end

        if (cmd.emit_data)
        begin
            valid_next[off_reg]  = !is_last_disk;
            par_next             = xor_val;
            flush_idx_next       = '0;
            out_valid_next       = 1'b1;
            out_next.disk_index   = 4'(disk_reg);
            out_next.stripe_index = stripe_cnt_reg;
            out_next.byte_offset  = 5'(off_reg);
            out_next.out_byte     = byte_reg;
            out_next.is_parity    = 1'b0;
            out_next.last_of_run  = !is_last_disk && !fin_reg;
        end

        if (cmd.emit_par)
        begin
            flush_idx_next        = OW'(off_inc);
            out_valid_next        = 1'b1;
            out_next.disk_index   = 4'(par_disk);
            out_next.stripe_index = stripe_cnt_reg;
            out_next.byte_offset  = 5'(off_reg);
            out_next.out_byte     = par_reg;
            out_next.is_parity    = 1'b1;
            out_next.last_of_run  = !fin_reg || (BSW'(off_reg) == bs_last);
        end

        if (cmd.emit_flush)
        begin
            flush_idx_next        = flush_idx_reg + OW'(1);
            out_valid_next        = 1'b1;
            out_next.disk_index   = 4'(par_disk);
            out_next.stripe_index = stripe_cnt_reg;
            out_next.byte_offset  = 5'(flush_idx_reg);
            out_next.out_byte     = flush_val;
            out_next.is_parity    = 1'b1;
            out_next.last_of_run  = (BSW'(flush_idx_reg) == bs_last);
        end

        // Advance to the next offset, disk and stripe; a final beat restarts.
        if (cmd.finish)
        begin
            if (fin_reg)
            begin
                offset_cnt_next = '0;
                disk_cnt_next   = '0;
                stripe_cnt_next = '0;
                valid_next      = '0;
            end
            else if (off_inc >= bs_eff)
            begin
                offset_cnt_next = '0;
                if (disk_reg == last_data)
                begin
                    disk_cnt_next   = '0;
                    stripe_cnt_next = stripe_cnt_reg + 16'd1;
                end
                else
                begin
                    disk_cnt_next = disk_reg + DKW'(1);
                end
            end
            else
            begin
                offset_cnt_next = OW'(off_inc);
                disk_cnt_next   = disk_reg;
            end
        end

        if (cfg_we)
        begin
            case (cfg_index)
                xpsg_pkg::REG_NUM_DISKS:
                begin
                    num_disks_next  = cfg_data[4:0];
                    offset_cnt_next = '0;
                    disk_cnt_next   = '0;
                    stripe_cnt_next = '0;
                    valid_next      = '0;
                end
                xpsg_pkg::REG_BLOCK_SIZE:
                begin
                    block_size_next = cfg_data[5:0];
                    offset_cnt_next = '0;
                    disk_cnt_next   = '0;
                    stripe_cnt_next = '0;
                    valid_next      = '0;
                end
                default:
                begin
                    num_disks_next = num_disks_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_disks_reg  <= xpsg_pkg::NUM_DISKS_RST;
            block_size_reg <= xpsg_pkg::BLOCK_SIZE_RST;
            offset_cnt_reg <= '0;
            disk_cnt_reg   <= '0;
            stripe_cnt_reg <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            num_disks_reg  <= num_disks_next;
            block_size_reg <= block_size_next;
            offset_cnt_reg <= offset_cnt_next;
            disk_cnt_reg   <= disk_cnt_next;
            stripe_cnt_reg <= stripe_cnt_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg       <= off_next;
        disk_reg      <= disk_next;
        byte_reg      <= byte_next;
        fin_reg       <= fin_next;
        par_reg       <= par_next;
        flush_idx_reg <= flush_idx_next;
        out_reg       <= out_next;
    end

    assign sts.out_free  = out_free;
    assign sts.fin       = fin_reg;
    assign sts.last_disk = is_last_disk;
    assign sts.off_end   = (BSW'(off_reg) == bs_last);
    assign sts.flush_end = (BSW'(flush_idx_reg) == bs_last);

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### design/xor_parity_stripe_generator_core.sv
// Top level of the XOR parity stripe generator.
// Depends on xpsg_pkg, xpsg_ctrl, xpsg_datapath and assert_macros.svh.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one data byte a beat;
//   final_req marks the last byte of a data set. Output channel (out_valid /
//   out_stall / out_data) delivers one tagged byte a beat: the data byte on
//   its disk, then, on the last data disk, the finished parity byte for that
//   offset. A final byte also flushes every pending parity byte of the block.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   num_disks (index 0) or block_size (index 1); each write restarts the
//   stream. cfg_ready is high while no item is in work, and an offered
//   register write holds off the input for that cycle.
// Sequence: the parity store is a RAM with registered read; each item does a
//   read-modify-write: read on accept, data beat loaded in ST_DATA, parity
//   beat in ST_PAR on the last data disk, each flushed byte via ST_FL_RD and
//   ST_FL_EM. A first beat reaches out_data via the state and output registers.
// Reset: asynchronous, active low; num_disks=3, block_size=32, counters and
//   parity entries cleared (parity entries through valid bits, no sweep).
// Stall: a beat waits in the output register while out_stall is high; the
//   next item may be accepted meanwhile, and the block holds until there is
//   room for its first beat.

`include "assert_macros.svh"

module xor_parity_stripe_generator_core #(
    parameter int MAX_BLOCK = xpsg_pkg::MAX_BLOCK_DEF,
    parameter int MAX_DISKS = xpsg_pkg::MAX_DISKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  xpsg_pkg::in_beat_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output xpsg_pkg::out_beat_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [xpsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [xpsg_pkg::CFG_DATA_W-1:0] cfg_data
);

    xpsg_pkg::cmd_t cmd;
    xpsg_pkg::sts_t sts;
    logic           cfg_we;

    // A configuration beat moves on valid and ready together.
    assign cfg_we = cfg_valid && cfg_ready;

    xpsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    xpsg_datapath #(
        .MAX_BLOCK (MAX_BLOCK),
        .MAX_DISKS (MAX_DISKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Only load a beat when the output register has room.
    `XPSG_ASSERT(a_emit_room, clk, rst_n, (cmd.emit_data || cmd.emit_par || cmd.emit_flush) |-> sts.out_free, "beat loaded into a full output register")
    // At most one beat is loaded per cycle.
    `XPSG_ASSERT(a_one_emit, clk, rst_n, $onehot0({cmd.emit_data, cmd.emit_par, cmd.emit_flush}), "two beats loaded in one cycle")
    // An item ends only together with its last beat.
    `XPSG_ASSERT(a_finish_beat, clk, rst_n, cmd.finish |-> (cmd.emit_data || cmd.emit_par || cmd.emit_flush), "item ended without a beat")
    // An accepted item holds the input stalled right after its accept.
    `XPSG_ASSERT(a_accept_busy, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "input open right after an accept")
    // The parity RAM read port serves one requester at a time.
    `XPSG_NEVER(a_one_read, clk, rst_n, cmd.accept && cmd.rd_flush, "two parity reads in one cycle")

endmodule
